FILE: rtl/lbs_pkg.sv
// Shared constants, codes and control types of the skinning block.
`default_nettype none
package lbs_pkg;

    localparam int POS_W          = 32;
    localparam int SLOT_IN_W      = 6;
    localparam int ELEM_W         = 4;
    localparam int IDX_W          = 6;
    localparam int WGT_W          = 16;
    localparam int PACKED_INF     = 4;
    localparam int IDXS_W         = IDX_W * PACKED_INF;
    localparam int WGTS_W         = WGT_W * PACKED_INF;
    localparam int MAT_ELEMS      = 16;
    localparam int FRAC_W         = 16;
    localparam int MAX_BONES_DEF  = 64;
    localparam int INFLUENCES_DEF = 4;
    localparam int PROD_W         = 2 * POS_W;
    localparam int FLOOR_W        = PROD_W - FRAC_W;
    localparam int ROW_W          = 50;
    localparam int WP_W           = 48;
    localparam int ACC_W          = 51;
    localparam int REM_W          = ACC_W + 1;
    localparam int QUO_W          = 32;
    localparam int STEP_W         = 5;
    localparam int INF_W          = 2;
    localparam int INF_CNT_W      = 3;
    localparam int BONE_EXT_W     = 9;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_VERTEX = 1'b1;

    localparam logic signed [POS_W-1:0] ONE_Q = 32'sh0001_0000;

    typedef enum logic [1:0] {
        COORD_X = 2'd0,
        COORD_Y = 2'd1,
        COORD_Z = 2'd2,
        COORD_W = 2'd3
    } coord_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_DIV_START,
        ST_DIV_STEP,
        ST_DIV_DONE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              wr_en;
        logic              capture;
        logic              clr_acc;
        logic              issue;
        logic [ELEM_W-1:0] elem;
        logic [INF_W-1:0]  infl;
        logic              div_start;
        logic              div_step;
        logic              div_done;
        coord_t            coord;
        logic              out_load;
    } cmd_t;

    typedef struct packed {
        logic infl_ok;
        logic busy;
        logic w_zero;
    } status_t;

endpackage
`default_nettype wire

FILE: rtl/lbs_if.sv
// Handshake channels of the skinning block: request and response.
`default_nettype none
interface lbs_in_if;
    import lbs_pkg::*;

    logic                           valid;
    logic                           ready;
    logic                           req_type;
    logic [SLOT_IN_W-1:0]           matrix_slot;
    logic [ELEM_W-1:0]              matrix_element;
    logic signed [POS_W-1:0]        matrix_value;
    logic signed [POS_W-1:0]        pos_x;
    logic signed [POS_W-1:0]        pos_y;
    logic signed [POS_W-1:0]        pos_z;
    logic [IDXS_W-1:0]              bone_indices;
    logic [WGTS_W-1:0]              bone_weights;

    modport source (
        output valid, req_type, matrix_slot, matrix_element, matrix_value,
               pos_x, pos_y, pos_z, bone_indices, bone_weights,
        input  ready
    );
    modport sink (
        input  valid, req_type, matrix_slot, matrix_element, matrix_value,
               pos_x, pos_y, pos_z, bone_indices, bone_weights,
        output ready
    );
    modport mon (
        input valid, ready, req_type, matrix_slot, matrix_element, matrix_value,
              pos_x, pos_y, pos_z, bone_indices, bone_weights
    );
endinterface

interface lbs_out_if;
    import lbs_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] anim_x;
    logic signed [POS_W-1:0] anim_y;
    logic signed [POS_W-1:0] anim_z;
    logic                    w_zero;

    modport source (output valid, anim_x, anim_y, anim_z, w_zero, input ready);
    modport sink (input valid, anim_x, anim_y, anim_z, w_zero, output ready);
    modport mon (input valid, ready, anim_x, anim_y, anim_z, w_zero);
endinterface
`default_nettype wire

FILE: rtl/lbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/lbs_ctrl.sv
// Sequencer of the skinning block: element reads, divide steps and result handoff.
`default_nettype none
module lbs_ctrl #(
    parameter int INFLUENCES = lbs_pkg::INFLUENCES_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    input  wire logic            req_type,
    output logic                 req_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire lbs_pkg::status_t status,
    output lbs_pkg::cmd_t        cmd
);
    import lbs_pkg::*;

    localparam int EFF_INF = (INFLUENCES < PACKED_INF) ? INFLUENCES : PACKED_INF;
    localparam logic [INF_CNT_W-1:0] INF_END = INF_CNT_W'(EFF_INF);
    localparam logic [ELEM_W-1:0] ELEM_LAST = ELEM_W'(MAT_ELEMS - 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUO_W - 1);

    state_t               state_reg, state_next;
    logic [INF_CNT_W-1:0] infl_reg, infl_next;
    logic [ELEM_W-1:0]    elem_reg, elem_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    coord_t               coord_reg, coord_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 take_vertex;
    logic                 inf_done;
    logic                 out_free;

    assign take_vertex = req_valid && (req_type == REQ_VERTEX);
    assign inf_done    = (infl_reg == INF_END);
    assign out_free    = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (take_vertex) state_next = ST_ISSUE;
            ST_ISSUE:     if (inf_done) state_next = ST_DRAIN;
            ST_DRAIN:
            begin
                if (!status.busy)
                begin
                    state_next = status.w_zero ? ST_FINISH : ST_DIV_START;
                end
            end
            ST_DIV_START: state_next = ST_DIV_STEP;
            ST_DIV_STEP:  if (step_reg == STEP_LAST) state_next = ST_DIV_DONE;
            ST_DIV_DONE:  state_next = (coord_reg == COORD_Z) ? ST_FINISH : ST_DIV_START;
            ST_FINISH:    if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.elem  = elem_reg;
        cmd.infl  = infl_reg[INF_W-1:0];
        cmd.coord = coord_reg;
        req_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.wr_en   = req_valid && (req_type == REQ_LOAD);
                cmd.capture = take_vertex;
                cmd.clr_acc = take_vertex;
            end
            ST_ISSUE:     cmd.issue = !inf_done && status.infl_ok;
            ST_DIV_START: cmd.div_start = 1'b1;
            ST_DIV_STEP:  cmd.div_step = 1'b1;
            ST_DIV_DONE:  cmd.div_done = 1'b1;
            ST_FINISH:    cmd.out_load = out_free;
            default:      cmd = '0;
        endcase
    end

    always_comb
    begin
        infl_next  = infl_reg;
        elem_next  = elem_reg;
        step_next  = step_reg;
        coord_next = coord_reg;
        case (state_reg)
            ST_IDLE:
            begin
                infl_next = '0;
                elem_next = '0;
            end
            ST_ISSUE:
            begin
                if (!inf_done)
                begin
                    if (!status.infl_ok)
                    begin
                        infl_next = infl_reg + 1'b1;
                    end
                    else
                    begin
                        elem_next = elem_reg + 1'b1;
                        if (elem_reg == ELEM_LAST)
                        begin
                            infl_next = infl_reg + 1'b1;
                        end
                    end
                end
            end
            ST_DRAIN:     coord_next = COORD_X;
            ST_DIV_START: step_next = '0;
            ST_DIV_STEP:  step_next = step_reg + 1'b1;
            ST_DIV_DONE:  coord_next = coord_t'(coord_reg + 1'b1);
            default:      step_next = step_reg;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            infl_reg      <= '0;
            elem_reg      <= '0;
            step_reg      <= '0;
            coord_reg     <= COORD_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            infl_reg      <= infl_next;
            elem_reg      <= elem_next;
            step_reg      <= step_next;
            coord_reg     <= coord_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/lbs_dp.sv
// Datapath: bone table, multiply-accumulate pipeline, restoring divider, result register.
`default_nettype none
module lbs_dp #(
    parameter int MAX_BONES = lbs_pkg::MAX_BONES_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire lbs_pkg::cmd_t                        cmd,
    output lbs_pkg::status_t                          status,
    input  wire logic [lbs_pkg::SLOT_IN_W-1:0]        matrix_slot,
    input  wire logic [lbs_pkg::ELEM_W-1:0]           matrix_element,
    input  wire logic signed [lbs_pkg::POS_W-1:0]     matrix_value,
    input  wire logic signed [lbs_pkg::POS_W-1:0]     pos_x,
    input  wire logic signed [lbs_pkg::POS_W-1:0]     pos_y,
    input  wire logic signed [lbs_pkg::POS_W-1:0]     pos_z,
    input  wire logic [lbs_pkg::IDXS_W-1:0]           bone_indices,
    input  wire logic [lbs_pkg::WGTS_W-1:0]           bone_weights,
    output logic signed [lbs_pkg::POS_W-1:0]          anim_x,
    output logic signed [lbs_pkg::POS_W-1:0]          anim_y,
    output logic signed [lbs_pkg::POS_W-1:0]          anim_z,
    output logic                                      w_zero
);
    import lbs_pkg::*;

    localparam int SLOT_W = $clog2(MAX_BONES);
    localparam int AW     = SLOT_W + ELEM_W;
    localparam int DEPTH  = MAX_BONES * MAT_ELEMS;
    localparam logic [BONE_EXT_W-1:0] BONE_LIM = BONE_EXT_W'(MAX_BONES);

    // table write and read
    logic [BONE_EXT_W-1:0]   slot_ext, bone_ext;
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    logic [POS_W-1:0]        ram_rdata;
    logic [IDX_W-1:0]        cur_idx;
    logic [WGT_W-1:0]        cur_w;

    // captured vertex
    logic signed [POS_W-1:0] px_reg, py_reg, pz_reg;
    logic [IDXS_W-1:0]       idx_reg;
    logic [WGTS_W-1:0]       wgt_reg;

    // pipeline
    logic                    v1_reg, v2_reg, v3_reg, v4_reg;
    logic [ELEM_W-1:0]       e1_reg, e2_reg;
    logic [INF_W-1:0]        i1_reg, i2_reg, i3_reg;
    logic [1:0]              r3_reg, r4_reg;
    logic signed [POS_W-1:0] m_val, p_sel;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [FLOOR_W-1:0] fl;
    logic signed [ROW_W-1:0] row_reg, row_next;
    logic signed [POS_W-1:0] row_sat;
    logic [WGT_W-1:0]        w3;
    logic signed [WGT_W:0]   w3_ext;
    logic signed [WP_W-1:0]  wprod_reg, wprod_next;
    logic signed [ACC_W-1:0] acc_x_reg, acc_y_reg, acc_z_reg, acc_w_reg;
    logic signed [ACC_W-1:0] acc_sel, acc_sum;

    // divider
    logic signed [ACC_W-1:0] num;
    logic [ACC_W-1:0]        a_mag, b_mag;
    logic [ACC_W-1:0]        b_reg;
    logic                    neg_reg, ovf_reg;
    logic [REM_W-1:0]        rem_reg, rem_trial;
    logic [QUO_W-1:0]        sh_reg, q_reg;
    logic                    ge;
    logic [QUO_W:0]          q_mag, q_clip, q_neg;
    logic [POS_W-1:0]        q_out;
    logic signed [POS_W-1:0] res_x_reg, res_y_reg, res_z_reg;

    assign slot_ext  = BONE_EXT_W'(matrix_slot);
    assign ram_we    = cmd.wr_en && (slot_ext < BONE_LIM);
    assign ram_waddr = {slot_ext[SLOT_W-1:0], matrix_element};

    assign cur_idx   = idx_reg[cmd.infl*IDX_W +: IDX_W];
    assign cur_w     = wgt_reg[cmd.infl*WGT_W +: WGT_W];
    assign bone_ext  = BONE_EXT_W'(cur_idx);
    assign ram_raddr = {bone_ext[SLOT_W-1:0], cmd.elem};

    lbs_ram #(
        .WIDTH (POS_W),
        .DEPTH (DEPTH)
    ) u_bone_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (matrix_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign status.infl_ok = (bone_ext < BONE_LIM) && (cur_w != '0);
    assign status.busy    = v1_reg || v2_reg || v3_reg || v4_reg;
    assign status.w_zero  = (acc_w_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            px_reg  <= pos_x;
            py_reg  <= pos_y;
            pz_reg  <= pos_z;
            idx_reg <= bone_indices;
            wgt_reg <= bone_weights;
        end
    end

    assign m_val = ram_rdata;

    always_comb
    begin
        case (e1_reg[1:0])
            2'd0:    p_sel = px_reg;
            2'd1:    p_sel = py_reg;
            2'd2:    p_sel = pz_reg;
            default: p_sel = ONE_Q;
        endcase
    end

    // floor by arithmetic shift, restart the row at column zero
    assign fl       = prod_reg[PROD_W-1:FRAC_W];
    assign row_next = ((e2_reg[1:0] == 2'd0) ? ROW_W'(0) : row_reg) + ROW_W'(fl);

    assign row_sat = (&row_reg[ROW_W-1:POS_W-1] || ~|row_reg[ROW_W-1:POS_W-1])
                   ? row_reg[POS_W-1:0]
                   : (row_reg[ROW_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

    assign w3         = wgt_reg[i3_reg*WGT_W +: WGT_W];
    assign w3_ext     = {1'b0, w3};
    assign wprod_next = WP_W'(row_sat) * WP_W'(w3_ext);

    always_comb
    begin
        case (r4_reg)
            2'd0:    acc_sel = acc_x_reg;
            2'd1:    acc_sel = acc_y_reg;
            2'd2:    acc_sel = acc_z_reg;
            default: acc_sel = acc_w_reg;
        endcase
    end

    assign acc_sum = acc_sel + ACC_W'(wprod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg && (e2_reg[1:0] == 2'd3);
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e1_reg    <= cmd.elem;
        i1_reg    <= cmd.infl;
        prod_reg  <= m_val * p_sel;
        e2_reg    <= e1_reg;
        i2_reg    <= i1_reg;
        if (v2_reg)
        begin
            row_reg <= row_next;
            r3_reg  <= e2_reg[3:2];
            i3_reg  <= i2_reg;
        end
        wprod_reg <= wprod_next;
        r4_reg    <= r3_reg;
        if (cmd.clr_acc)
        begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            acc_z_reg <= '0;
            acc_w_reg <= '0;
        end
        else if (v4_reg)
        begin
            case (r4_reg)
                2'd0:    acc_x_reg <= acc_sum;
                2'd1:    acc_y_reg <= acc_sum;
                2'd2:    acc_z_reg <= acc_sum;
                default: acc_w_reg <= acc_sum;
            endcase
        end
    end

    always_comb
    begin
        case (cmd.coord)
            COORD_X: num = acc_x_reg;
            COORD_Y: num = acc_y_reg;
            COORD_Z: num = acc_z_reg;
            default: num = acc_w_reg;
        endcase
    end

    assign a_mag = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
    assign b_mag = acc_w_reg[ACC_W-1] ? ACC_W'(-acc_w_reg) : ACC_W'(acc_w_reg);

    assign rem_trial = {rem_reg[REM_W-2:0], sh_reg[QUO_W-1]};
    assign ge        = rem_trial >= REM_W'(b_reg);

    assign q_mag  = ovf_reg ? {1'b1, QUO_W'(0)} : {1'b0, q_reg};
    assign q_clip = neg_reg
                  ? ((q_mag > 33'h0_8000_0000) ? 33'h0_8000_0000 : q_mag)
                  : ((q_mag > 33'h0_7FFF_FFFF) ? 33'h0_7FFF_FFFF : q_mag);
    assign q_neg  = 33'h0 - q_clip;
    assign q_out  = neg_reg ? q_neg[POS_W-1:0] : q_clip[POS_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            b_reg   <= b_mag;
            neg_reg <= num[ACC_W-1] ^ acc_w_reg[ACC_W-1];
            ovf_reg <= ACC_W'(a_mag[ACC_W-1:FRAC_W]) >= b_mag;
            rem_reg <= REM_W'(a_mag[ACC_W-1:FRAC_W]);
            sh_reg  <= {a_mag[FRAC_W-1:0], FRAC_W'(0)};
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? (rem_trial - REM_W'(b_reg)) : rem_trial;
            sh_reg  <= {sh_reg[QUO_W-2:0], 1'b0};
            q_reg   <= {q_reg[QUO_W-2:0], ge};
        end
        if (cmd.div_done)
        begin
            case (cmd.coord)
                COORD_X: res_x_reg <= q_out;
                COORD_Y: res_y_reg <= q_out;
                default: res_z_reg <= q_out;
            endcase
        end
        if (cmd.out_load)
        begin
            anim_x <= status.w_zero ? '0 : res_x_reg;
            anim_y <= status.w_zero ? '0 : res_y_reg;
            anim_z <= status.w_zero ? '0 : res_z_reg;
            w_zero <= status.w_zero;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/linear_blend_skinning.sv
// Top level of the four-influence linear blend skinning block.
//
//   channel  dir  transfer          payload
//   req      in   valid && ready    req_type, matrix slot/element/value, pos, bones, weights
//   rsp      out  valid && ready    anim_x, anim_y, anim_z, w_zero
//
// A load transfer writes the bone table and leaves req ready.
// A vertex reads all sixteen table elements of each used influence (one table
// read per cycle on the single read port) and skips the others, drains the
// pipeline, then, unless w is zero, runs the one-bit-per-cycle divider for x, y and z.
// Reset clears control only; the bone table is not cleared.
// The result waits in the rsp register; req accepts again while it waits.
`default_nettype none
module linear_blend_skinning #(
    parameter int MAX_BONES  = lbs_pkg::MAX_BONES_DEF,
    parameter int INFLUENCES = lbs_pkg::INFLUENCES_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lbs_in_if.sink     req,
    lbs_out_if.source  rsp
);
    import lbs_pkg::*;

    cmd_t    cmd;
    status_t status;

    lbs_ctrl #(
        .INFLUENCES (INFLUENCES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.req_type),
        .req_ready (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    lbs_dp #(
        .MAX_BONES (MAX_BONES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .matrix_slot    (req.matrix_slot),
        .matrix_element (req.matrix_element),
        .matrix_value   (req.matrix_value),
        .pos_x          (req.pos_x),
        .pos_y          (req.pos_y),
        .pos_z          (req.pos_z),
        .bone_indices   (req.bone_indices),
        .bone_weights   (req.bone_weights),
        .anim_x         (rsp.anim_x),
        .anim_y         (rsp.anim_y),
        .anim_z         (rsp.anim_z),
        .w_zero         (rsp.w_zero)
    );
endmodule
`default_nettype wire

FILE: rtl/lbs_checker.sv
// Port-level checks of the skinning block and their bind to the top level.
`default_nettype none
module lbs_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          req_valid,
    input wire logic                          req_ready,
    input wire logic                          req_type,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic signed [lbs_pkg::POS_W-1:0] anim_x,
    input wire logic signed [lbs_pkg::POS_W-1:0] anim_y,
    input wire logic signed [lbs_pkg::POS_W-1:0] anim_z,
    input wire logic                          w_zero
);
    import lbs_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp valid dropped before transfer");

    a_zero_w: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && w_zero |-> (anim_x == 0) && (anim_y == 0) && (anim_z == 0))
        else $error("nonzero coordinates with zero w");

    a_vertex_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_type == REQ_VERTEX) |=> !req_ready)
        else $error("req ready right after a vertex transfer");

    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_type == REQ_LOAD) |=> req_ready)
        else $error("req not ready after a load transfer");
endmodule

bind linear_blend_skinning lbs_checker u_lbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_type  (req.req_type),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .anim_x    (rsp.anim_x),
    .anim_y    (rsp.anim_y),
    .anim_z    (rsp.anim_z),
    .w_zero    (rsp.w_zero)
);
`default_nettype wire
